>>> hw/rtl/price_level_order_queue_core_defines.svh
// ----------------------------------------------------------------------------
// price_level_order_queue_core_defines
// Assertion macros shared by the order queue RTL.
// ----------------------------------------------------------------------------
`ifndef PRICE_LEVEL_ORDER_QUEUE_CORE_DEFINES_SVH
`define PRICE_LEVEL_ORDER_QUEUE_CORE_DEFINES_SVH

// same-cycle implication
`define PLOQ_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("order queue check failed");

// next-cycle implication
`define PLOQ_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("order queue check failed");

`endif

>>> hw/rtl/ploq_pkg.sv
// ----------------------------------------------------------------------------
// ploq_pkg
// Field widths, operation and status codes, and the queue entry type.
// ----------------------------------------------------------------------------
package ploq_pkg;

    localparam int unsigned ModeW     = 2;
    localparam int unsigned IdW       = 32;
    localparam int unsigned QtyW      = 32;
    localparam int unsigned StatusW   = 3;
    localparam int unsigned TotalOutW = 38;
    localparam int unsigned CountOutW = 7;

    localparam logic [ModeW-1:0] MODE_ADD    = 2'd0;
    localparam logic [ModeW-1:0] MODE_REMOVE = 2'd1;
    localparam logic [ModeW-1:0] MODE_FILL   = 2'd2;

    localparam logic [StatusW-1:0] ST_OK        = 3'd0;
    localparam logic [StatusW-1:0] ST_ZERO      = 3'd1;
    localparam logic [StatusW-1:0] ST_NOT_FOUND = 3'd2;
    localparam logic [StatusW-1:0] ST_EXCEEDS   = 3'd3;
    localparam logic [StatusW-1:0] ST_FULL      = 3'd4;

    typedef struct packed {
        logic [IdW-1:0]  id;
        logic [QtyW-1:0] remaining;
    } entry_t;

endpackage

>>> hw/rtl/price_level_order_queue_core.sv
// Add, no-op, rejected add and rejected fill pass from idle through S_FRNT and S_OUT to a result beat.
// Remove: S_SRCH scans for the id; when it is found, S_SHFT closes the gap; both end in S_FRNT, S_OUT.
// Fill: S_FCMP retires or reduces front orders one by one, then S_FRNT and S_OUT; one item is in work at a time.
// The next input beat is taken once the result sits in the output register.
// Cycle count is set by the single read and single write port of the entry memory.
// Reset clears count, total and head pointer; entry memory contents are not cleared.
// ----------------------------------------------------------------------------
// price_level_order_queue_core
// Time-ordered order queue of one price level kept in a circular entry
// memory, with running total, id search with gap closing, and front fill.
// ----------------------------------------------------------------------------
`include "price_level_order_queue_core_defines.svh"

module price_level_order_queue_core #(
    parameter int QUEUE_DEPTH = 64
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            in_valid,
    output logic                            in_stall,
    input  logic [ploq_pkg::ModeW-1:0]      mode,
    input  logic [ploq_pkg::IdW-1:0]        order_id,
    input  logic [ploq_pkg::QtyW-1:0]       quantity,
    output logic                            out_valid,
    input  logic                            out_stall,
    output logic [ploq_pkg::StatusW-1:0]    status,
    output logic [ploq_pkg::TotalOutW-1:0]  total_quantity,
    output logic [ploq_pkg::CountOutW-1:0]  order_count,
    output logic                            is_empty,
    output logic [ploq_pkg::IdW-1:0]        front_id,
    output logic [ploq_pkg::QtyW-1:0]       front_remaining
);

    localparam int AW = $clog2(QUEUE_DEPTH);
    localparam int CW = $clog2(QUEUE_DEPTH + 1);
    localparam int TW = ploq_pkg::QtyW + CW;

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_SRCH = 3'd1;
    localparam logic [2:0] S_SHFT = 3'd2;
    localparam logic [2:0] S_FCMP = 3'd3;
    localparam logic [2:0] S_FRNT = 3'd4;
    localparam logic [2:0] S_OUT  = 3'd5;

    // logical position to memory address
    function automatic logic [AW-1:0] phys(input logic [AW-1:0] base, input logic [CW-1:0] off);
        logic [AW:0] sum;
        sum = {1'b0, base} + (AW+1)'(off);
        if (sum >= (AW+1)'(QUEUE_DEPTH)) begin
            sum = sum - (AW+1)'(QUEUE_DEPTH);
        end
        return sum[AW-1:0];
    endfunction

    ploq_pkg::entry_t mem [QUEUE_DEPTH];

    logic [2:0]                     state_reg, state_next;
    logic [AW-1:0]                  head_reg, head_next;
    logic [CW-1:0]                  count_reg, count_next;
    logic [TW-1:0]                  total_reg, total_next;
    logic [CW-1:0]                  idx_reg, idx_next;
    logic                           chk_vld_reg, chk_vld_next;
    logic [CW-1:0]                  chk_idx_reg, chk_idx_next;
    logic [ploq_pkg::QtyW-1:0]      left_reg, left_next;
    logic [ploq_pkg::IdW-1:0]       id_reg, id_next;
    logic [ploq_pkg::StatusW-1:0]   st_reg, st_next;
    logic                           out_valid_reg, out_valid_next;

    logic [ploq_pkg::StatusW-1:0]   status_reg;
    logic [ploq_pkg::TotalOutW-1:0] total_out_reg;
    logic [ploq_pkg::CountOutW-1:0] count_out_reg;
    logic                           empty_out_reg;
    logic [ploq_pkg::IdW-1:0]       front_id_reg;
    logic [ploq_pkg::QtyW-1:0]      front_rem_reg;

    logic                           rd_en, wr_en, out_load;
    logic [AW-1:0]                  rd_addr, wr_addr;
    ploq_pkg::entry_t               wr_data, rd_data_reg;
    logic                           hit;
    logic [ploq_pkg::QtyW-1:0]      rem;

    assign in_stall = (state_reg != S_IDLE);
    assign hit      = chk_vld_reg && (rd_data_reg.id == id_reg);
    assign rem      = rd_data_reg.remaining;
    assign out_load = (state_reg == S_OUT) && (!out_valid_reg || !out_stall);

    always_comb
    begin
        state_next   = state_reg;
        head_next    = head_reg;
        count_next   = count_reg;
        total_next   = total_reg;
        idx_next     = idx_reg;
        chk_vld_next = chk_vld_reg;
        chk_idx_next = chk_idx_reg;
        left_next    = left_reg;
        id_next      = id_reg;
        st_next      = st_reg;
        rd_en        = 1'b0;
        rd_addr      = head_reg;
        wr_en        = 1'b0;
        wr_addr      = head_reg;
        wr_data      = rd_data_reg;

        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    id_next      = order_id;
                    st_next      = ploq_pkg::ST_OK;
                    idx_next     = '0;
                    chk_vld_next = 1'b0;
                    state_next   = S_FRNT;
                    unique case (mode)
                        ploq_pkg::MODE_ADD:
                        begin
                            if (quantity == '0)
                            begin
                                st_next = ploq_pkg::ST_ZERO;
                            end
                            else if (count_reg >= CW'(QUEUE_DEPTH))
                            begin
                                st_next = ploq_pkg::ST_FULL;
                            end
                            else
                            begin
                                wr_en      = 1'b1;
                                wr_addr    = phys(head_reg, count_reg);
                                wr_data    = '{id: order_id, remaining: quantity};
                                count_next = count_reg + CW'(1);
                                total_next = total_reg + TW'(quantity);
                            end
                        end
                        ploq_pkg::MODE_REMOVE:
                        begin
                            state_next = S_SRCH;
                        end
                        ploq_pkg::MODE_FILL:
                        begin
                            if (TW'(quantity) > total_reg)
                            begin
                                st_next = ploq_pkg::ST_EXCEEDS;
                            end
                            else if (quantity != '0)
                            begin
                                rd_en      = 1'b1;
                                left_next  = quantity;
                                state_next = S_FCMP;
                            end
                        end
                        default:
                        begin
                            st_next = ploq_pkg::ST_OK;
                        end
                    endcase
                end
            end
            S_SRCH:
            begin
                if (hit)
                begin
                    total_next   = total_reg - TW'(rem);
                    idx_next     = chk_idx_reg + CW'(1);
                    chk_vld_next = 1'b0;
                    state_next   = S_SHFT;
                end
                else if (idx_reg < count_reg)
                begin
                    rd_en        = 1'b1;
                    rd_addr      = phys(head_reg, idx_reg);
                    chk_vld_next = 1'b1;
                    chk_idx_next = idx_reg;
                    idx_next     = idx_reg + CW'(1);
                end
                else
                begin
                    st_next      = ploq_pkg::ST_NOT_FOUND;
                    chk_vld_next = 1'b0;
                    state_next   = S_FRNT;
                end
            end
            S_SHFT:
            begin
                if (chk_vld_reg)
                begin
                    wr_en   = 1'b1;
                    wr_addr = phys(head_reg, chk_idx_reg - CW'(1));
                    wr_data = rd_data_reg;
                end
                if (idx_reg < count_reg)
                begin
                    rd_en        = 1'b1;
                    rd_addr      = phys(head_reg, idx_reg);
                    chk_vld_next = 1'b1;
                    chk_idx_next = idx_reg;
                    idx_next     = idx_reg + CW'(1);
                end
                else
                begin
                    chk_vld_next = 1'b0;
                    count_next   = count_reg - CW'(1);
                    state_next   = S_FRNT;
                end
            end
            S_FCMP:
            begin
                if (rem <= left_reg)
                begin
                    left_next  = left_reg - rem;
                    total_next = total_reg - TW'(rem);
                    head_next  = phys(head_reg, CW'(1));
                    count_next = count_reg - CW'(1);
                    if ((left_reg == rem) || (count_reg == CW'(1)))
                    begin
                        state_next = S_FRNT;
                    end
                    else
                    begin
                        rd_en   = 1'b1;
                        rd_addr = phys(head_reg, CW'(1));
                    end
                end
                else
                begin
                    wr_en      = 1'b1;
                    wr_addr    = head_reg;
                    wr_data    = '{id: rd_data_reg.id, remaining: rem - left_reg};
                    total_next = total_reg - TW'(left_reg);
                    state_next = S_FRNT;
                end
            end
            S_FRNT:
            begin
                rd_en      = 1'b1;
                rd_addr    = head_reg;
                state_next = S_OUT;
            end
            S_OUT:
            begin
                if (out_load)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (out_load)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_valid_reg && !out_stall)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            head_reg      <= '0;
            count_reg     <= '0;
            total_reg     <= '0;
            idx_reg       <= '0;
            chk_vld_reg   <= 1'b0;
            chk_idx_reg   <= '0;
            st_reg        <= ploq_pkg::ST_OK;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            head_reg      <= head_next;
            count_reg     <= count_next;
            total_reg     <= total_next;
            idx_reg       <= idx_next;
            chk_vld_reg   <= chk_vld_next;
            chk_idx_reg   <= chk_idx_next;
            st_reg        <= st_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        left_reg <= left_next;
        id_reg   <= id_next;
        if (out_load)
        begin
            status_reg    <= st_reg;
            total_out_reg <= ploq_pkg::TotalOutW'(total_reg);
            count_out_reg <= ploq_pkg::CountOutW'(count_reg);
            empty_out_reg <= (count_reg == '0);
            front_id_reg  <= (count_reg == '0) ? '0 : rd_data_reg.id;
            front_rem_reg <= (count_reg == '0) ? '0 : rd_data_reg.remaining;
        end
    end

    assign out_valid       = out_valid_reg;
    assign status          = status_reg;
    assign total_quantity  = total_out_reg;
    assign order_count     = count_out_reg;
    assign is_empty        = empty_out_reg;
    assign front_id        = front_id_reg;
    assign front_remaining = front_rem_reg;

    `PLOQ_ASSERT_NEXT(a_accept_starts_work, clk, rst_n, in_valid && !in_stall, state_reg != S_IDLE)
    `PLOQ_ASSERT_NOW(a_result_from_out, clk, rst_n, $rose(out_valid_reg), $past(state_reg) == S_OUT)
    `PLOQ_ASSERT_NOW(a_empty_total_zero, clk, rst_n, count_reg == '0, total_reg == '0)

endmodule
